FILE: rtl/upd_pkg.sv
package upd_pkg;

  // Character buffer: up to five held characters plus the one being looked at.
  localparam int BUF_DEPTH = 6;
  localparam int CNT_W     = 3;
  localparam int MODE_W    = 2;

  localparam logic [MODE_W-1:0] MODE_PLAIN = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PCT   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_AMP   = 2'd2;

  localparam logic [7:0] CH_PCT   = 8'h25;  // '%'
  localparam logic [7:0] CH_AMP   = 8'h26;  // '&'
  localparam logic [7:0] CH_QUOTE = 8'h27;  // single quote
  localparam logic [7:0] CH_SEMI  = 8'h3b;

  localparam logic [CNT_W-1:0] APOS_LEN = 3'd5;  // held chars when "apos;" completes
  localparam logic [CNT_W-1:0] AMP_LEN  = 3'd4;  // held chars when "amp;" completes

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [CNT_W-1:0]  p;       // held count
    logic [7:0]        c;       // character under test
    logic [7:0]        h1;      // second held character
    logic              ap;      // "apos;" still possible
    logic              am;      // "amp;" still possible
    logic              at_end;  // resolve held chars, no new character
  } step_in_t;

  typedef struct packed {
    logic              emit;
    logic [7:0]        byte_val;
    logic [CNT_W-1:0]  drop;    // entries removed from the buffer head
    logic [CNT_W-1:0]  p_next;
    logic [MODE_W-1:0] mode_next;
    logic              ap_next;
    logic              am_next;
  } step_out_t;

  typedef struct packed {
    logic       emit;
    logic [7:0] byte_val;
    logic       finish;
    logic       last;
  } out_req_t;

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
           (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_nib(input logic [7:0] c);
    logic [7:0] v;
    if (c <= 8'h39) v = c - 8'h30;
    else if (c >= 8'h61) v = c - 8'h57;
    else v = c - 8'h37;
    return v[3:0];
  endfunction

  // Expected character once k characters are held ("&" is the first).
  function automatic logic [7:0] apos_char(input logic [CNT_W-1:0] k);
    logic [7:0] r;
    unique case (k)
      3'd1:    r = 8'h61;
      3'd2:    r = 8'h70;
      3'd3:    r = 8'h6f;
      3'd4:    r = 8'h73;
      3'd5:    r = CH_SEMI;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] amp_char(input logic [CNT_W-1:0] k);
    logic [7:0] r;
    unique case (k)
      3'd1:    r = 8'h61;
      3'd2:    r = 8'h6d;
      3'd3:    r = 8'h70;
      3'd4:    r = CH_SEMI;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/upd_step.sv
// One decode step: looks at the held state and one character, decides what to
// emit, how many buffer entries to retire and the next match state.
module upd_step (
  input  upd_pkg::step_in_t  si,
  output upd_pkg::step_out_t so
);

  logic ap_n;
  logic am_n;
  logic [upd_pkg::CNT_W-1:0] p_inc;

  assign ap_n  = si.ap && (si.c == upd_pkg::apos_char(si.p));
  assign am_n  = si.am && (si.p <= upd_pkg::AMP_LEN) && (si.c == upd_pkg::amp_char(si.p));
  assign p_inc = si.p + 3'd1;

  always_comb begin
    so           = '0;
    so.p_next    = si.p;
    so.mode_next = si.mode;
    so.ap_next   = si.ap;
    so.am_next   = si.am;
    if (si.at_end) begin
      // string ended with a match open: drop '%' or emit '&', replay the rest
      so.emit      = (si.mode == upd_pkg::MODE_AMP);
      so.byte_val  = upd_pkg::CH_AMP;
      so.drop      = 3'd1;
      so.p_next    = '0;
      so.mode_next = upd_pkg::MODE_PLAIN;
    end else begin
      unique case (si.mode)
        upd_pkg::MODE_PCT: begin
          if (si.p <= 3'd1) begin
            if (upd_pkg::is_hex(si.c)) begin
              so.p_next = p_inc;
            end else begin
              so.drop      = 3'd1;
              so.p_next    = '0;
              so.mode_next = upd_pkg::MODE_PLAIN;
            end
          end else begin
            so.p_next    = '0;
            so.mode_next = upd_pkg::MODE_PLAIN;
            if (upd_pkg::is_hex(si.h1) && upd_pkg::is_hex(si.c)) begin
              so.emit     = 1'b1;
              so.byte_val = {upd_pkg::hex_nib(si.h1), upd_pkg::hex_nib(si.c)};
              so.drop     = p_inc;
            end else begin
              so.drop = 3'd1;
            end
          end
        end
        upd_pkg::MODE_AMP: begin
          if (ap_n && si.p == upd_pkg::APOS_LEN) begin
            so.emit      = 1'b1;
            so.byte_val  = upd_pkg::CH_QUOTE;
            so.drop      = p_inc;
            so.p_next    = '0;
            so.mode_next = upd_pkg::MODE_PLAIN;
          end else if (am_n && si.p == upd_pkg::AMP_LEN) begin
            so.emit      = 1'b1;
            so.byte_val  = upd_pkg::CH_AMP;
            so.drop      = p_inc;
            so.p_next    = '0;
            so.mode_next = upd_pkg::MODE_PLAIN;
          end else if (ap_n || am_n) begin
            so.p_next  = p_inc;
            so.ap_next = ap_n;
            so.am_next = am_n;
          end else begin
            so.emit      = 1'b1;
            so.byte_val  = upd_pkg::CH_AMP;
            so.drop      = 3'd1;
            so.p_next    = '0;
            so.mode_next = upd_pkg::MODE_PLAIN;
          end
        end
        default: begin
          if (si.c == upd_pkg::CH_PCT) begin
            so.p_next    = 3'd1;
            so.mode_next = upd_pkg::MODE_PCT;
          end else if (si.c == upd_pkg::CH_AMP) begin
            so.p_next    = 3'd1;
            so.mode_next = upd_pkg::MODE_AMP;
            so.ap_next   = 1'b1;
            so.am_next   = 1'b1;
          end else begin
            so.emit     = 1'b1;
            so.byte_val = si.c;
            so.drop     = 3'd1;
            so.p_next   = '0;
          end
        end
      endcase
    end
  end

endmodule

FILE: rtl/upd_out.sv
// Result staging: one pending byte (so the last one can be tagged) and the
// output register.
module upd_out (
  input  logic              clk,
  input  logic              rst,
  input  upd_pkg::out_req_t req,
  output logic              stall,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [7:0]        m_tdata,
  output logic              m_tuser,
  output logic              m_tlast
);

  logic       pend_v;
  logic [7:0] pend_b;
  logic       slot_free;
  logic       need_push;

  assign slot_free = !m_tvalid || m_tready;
  assign need_push = (req.emit && pend_v) || (req.finish && (pend_v || req.last));
  assign stall     = need_push && !slot_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_v   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (need_push && slot_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (!stall) begin
        if (req.emit) begin
          pend_v <= 1'b1;
        end else if (req.finish) begin
          pend_v <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (need_push && slot_free) begin
      m_tdata <= pend_v ? pend_b : 8'h00;
      m_tuser <= pend_v;
      m_tlast <= req.finish && req.last;
    end
    if (!stall && req.emit) begin
      pend_b <= req.byte_val;
    end
  end

endmodule

FILE: rtl/uri_percent_entity_decoder.sv
// Channel  | Signals                         | Contents
// ---------+---------------------------------+-----------------------------------
// s (in)   | s_tvalid s_tready s_tdata s_tlast | tdata[7:0] in_char, tlast is_last
// m (out)  | m_tvalid m_tready m_tdata         | tdata[7:0] out_byte,
//          |   m_tuser m_tlast               |   tuser has_byte, tlast last
//
// One request at a time. After the accept, the shared step unit runs once
// per character under test (the new one plus any replayed held characters,
// up to six), once more for a match still open at end of string, and a
// final step flushes the pending byte; a step that must push a result waits
// while m_tready holds off output.
// rst is synchronous, active high; backpressure only freezes the sequencer.
module uri_percent_entity_decoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_char
  input  logic       s_tlast,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic       m_tuser,   // [0] has_byte
  output logic       m_tlast
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic state;
  logic last_flag;

  // buf[0 .. p-1] are held characters, buf[p .. len-1] still wait for a step
  logic [7:0]                  cbuf [upd_pkg::BUF_DEPTH];
  logic [upd_pkg::CNT_W-1:0]   len;
  logic [upd_pkg::CNT_W-1:0]   p;
  logic [upd_pkg::MODE_W-1:0]  mode;
  logic                        ap;
  logic                        am;

  logic char_step;
  logic end_step;
  logic finish;
  logic stall;
  logic do_step;
  logic accept;

  upd_pkg::step_in_t  si;
  upd_pkg::step_out_t so;
  upd_pkg::out_req_t  oreq;

  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign char_step = (state == ST_RUN) && (p < len);
  assign end_step  = (state == ST_RUN) && !(p < len) && last_flag && (p != '0);
  assign finish    = (state == ST_RUN) && !char_step && !end_step;
  assign do_step   = (char_step || end_step) && !stall;

  always_comb begin
    si.mode   = mode;
    si.p      = p;
    si.c      = cbuf[p];
    si.h1     = cbuf[1];
    si.ap     = ap;
    si.am     = am;
    si.at_end = !char_step;
  end

  upd_step u_step (
    .si (si),
    .so (so)
  );

  always_comb begin
    oreq.emit     = (char_step || end_step) && so.emit;
    oreq.byte_val = so.byte_val;
    oreq.finish   = finish;
    oreq.last     = last_flag;
  end

  upd_out u_out (
    .clk      (clk),
    .rst      (rst),
    .req      (oreq),
    .stall    (stall),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // sequencer and match state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      len   <= '0;
      p     <= '0;
      mode  <= upd_pkg::MODE_PLAIN;
      ap    <= 1'b0;
      am    <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            len   <= len + 3'd1;
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (do_step) begin
            len  <= len - so.drop;
            p    <= so.p_next;
            mode <= so.mode_next;
            ap   <= so.ap_next;
            am   <= so.am_next;
          end else if (finish && !stall) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // character buffer: append on accept, retire from the head after a step
  always_ff @(posedge clk) begin
    if (accept) begin
      cbuf[len] <= s_tdata;
      last_flag <= s_tlast;
    end else if (do_step && so.drop != '0) begin
      for (int i = 0; i < upd_pkg::BUF_DEPTH; i++) begin
        for (int k = 1; k <= upd_pkg::BUF_DEPTH; k++) begin
          if (so.drop == k[upd_pkg::CNT_W-1:0] && i + k < upd_pkg::BUF_DEPTH) begin
            cbuf[i] <= cbuf[i+k];
          end
        end
      end
    end
  end

endmodule

FILE: rtl/upd_checker.sv
module upd_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tuser,
  input logic       m_tlast
);

  // one request in flight: no accept right after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request accepted while previous one still running");

  // a result without a byte only closes a string
  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tlast)
    else $error("empty result not marked last");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == 8'h00)
    else $error("empty result carries nonzero data");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result changed");

endmodule

bind uri_percent_entity_decoder upd_checker u_chk (.*);

FILE: tb/uri_percent_entity_decoder_test.sv
module uri_percent_entity_decoder_test;

  localparam int RANDOM_ITEMS = 155;
  localparam int LONG_HOLD    = 300;  // receiver stall, long enough to back up the input
  localparam int HOLD_AFTER   = 30;   // results seen before the long stall starts
  localparam int DRAIN_CYCLES = 40;   // margin after the longest replay
  localparam int MAX_REPORTS  = 60;

  // One decoded result as it leaves m_*.
  typedef struct packed {
    logic [7:0] value;
    logic       has_byte;
    logic       last;
  } decode_result_t;

  // One character request as it enters s_*.
  typedef struct packed {
    logic [7:0] ch;
    logic       is_last;
  } char_req_t;

  // How the expectation of a directed row is formed.
  typedef enum logic [1:0] {PREDICTED, NO_RESULT, ONE_RESULT} row_kind_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       is_last;
    row_kind_e  kind;
    logic [7:0] value;
    logic       has_byte;
    logic       last;
  } directed_row_t;

  typedef enum int {MATCH_NONE, MATCH_OPEN, MATCH_APOS, MATCH_AMP} entity_match_e;

  // Entity tails after the leading '&'.
  localparam logic [7:0] APOS_SEQ [5] = '{8'h61, 8'h70, 8'h6f, 8'h73, upd_pkg::CH_SEMI};
  localparam logic [7:0] AMP_SEQ  [4] = '{8'h61, 8'h6d, 8'h70, upd_pkg::CH_SEMI};

  // Directed part: extremes, percent escapes, entities, end-of-string cases.
  localparam int DIRECTED_N = 25;
  localparam directed_row_t DIRECTED_ROWS [DIRECTED_N] = '{
    // plain copy right after reset, zero and all-ones characters
    '{8'h41,  1'b0, ONE_RESULT, 8'h41, 1'b1, 1'b0},
    '{8'h00,  1'b0, ONE_RESULT, 8'h00, 1'b1, 1'b0},
    '{8'hff,  1'b0, ONE_RESULT, 8'hff, 1'b1, 1'b0},
    // %00 gives a zero byte
    '{upd_pkg::CH_PCT, 1'b0, NO_RESULT,  8'h00, 1'b0, 1'b0},
    '{8'h30,  1'b0, NO_RESULT,  8'h00, 1'b0, 1'b0},
    '{8'h30,  1'b0, ONE_RESULT, 8'h00, 1'b1, 1'b0},
    // %Ff, mixed case digits
    '{upd_pkg::CH_PCT, 1'b0, NO_RESULT,  8'h00, 1'b0, 1'b0},
    '{8'h46,  1'b0, NO_RESULT,  8'h00, 1'b0, 1'b0},
    '{8'h66,  1'b0, ONE_RESULT, 8'hff, 1'b1, 1'b0},
    // %aZ: bad second digit, '%' dropped and "aZ" decoded again
    '{upd_pkg::CH_PCT, 1'b0, NO_RESULT,  8'h00, 1'b0, 1'b0},
    '{8'h61,  1'b0, NO_RESULT,  8'h00, 1'b0, 1'b0},
    '{8'h5a,  1'b0, PREDICTED,  8'h00, 1'b0, 1'b0},
    // &apos;
    '{upd_pkg::CH_AMP, 1'b0, NO_RESULT,  8'h00, 1'b0, 1'b0},
    '{8'h61,  1'b0, NO_RESULT,  8'h00, 1'b0, 1'b0},
    '{8'h70,  1'b0, NO_RESULT,  8'h00, 1'b0, 1'b0},
    '{8'h6f,  1'b0, NO_RESULT,  8'h00, 1'b0, 1'b0},
    '{8'h73,  1'b0, NO_RESULT,  8'h00, 1'b0, 1'b0},
    '{upd_pkg::CH_SEMI, 1'b0, ONE_RESULT, upd_pkg::CH_QUOTE, 1'b1, 1'b0},
    // partial entity at end of string
    '{upd_pkg::CH_AMP, 1'b0, NO_RESULT,  8'h00, 1'b0, 1'b0},
    '{8'h61,  1'b0, NO_RESULT,  8'h00, 1'b0, 1'b0},
    '{8'h6d,  1'b1, PREDICTED,  8'h00, 1'b0, 1'b0},
    // '%' with one digit at end: '%' dropped, digit kept
    '{upd_pkg::CH_PCT, 1'b0, NO_RESULT,  8'h00, 1'b0, 1'b0},
    '{8'h34,  1'b1, ONE_RESULT, 8'h34, 1'b1, 1'b1},
    // lone '%' at end: empty end marker
    '{upd_pkg::CH_PCT, 1'b1, ONE_RESULT, 8'h00, 1'b0, 1'b1},
    // plain last character
    '{8'h71,  1'b1, ONE_RESULT, 8'h71, 1'b1, 1'b1}
  };

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;   // [7:0] in_char
  logic       s_tlast = 1'b0;    // is_last
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;           // [7:0] out_byte
  logic       m_tuser;           // [0] has_byte
  logic       m_tlast;           // last

  uri_percent_entity_decoder dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #4 clk = ~clk;

  // Decoder shadow state.
  logic [7:0]                 held_buf [5] = '{default: 8'h00};
  int unsigned                held_n = 0;
  logic [upd_pkg::MODE_W-1:0] scan_mode = upd_pkg::MODE_PLAIN;
  logic [7:0]                 replay_q [$];
  decode_result_t             step_results [$];   // results of the request being decoded
  decode_result_t             pending_bytes [$];  // results still owed by the block

  char_req_t random_q [$];

  int fail_count      = 0;
  int results_checked = 0;
  int chars_sent      = 0;
  int strings_sent    = 0;
  int escapes_seen    = 0;
  int entities_seen   = 0;
  int calm_left       = 0;

  function automatic int hex_value(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
    if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
    if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
    return -1;
  endfunction

  // Mostly back to back, sometimes a short gap, rarely a long one.
  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  task automatic push_byte(input logic [7:0] b);
    decode_result_t r;
    r.value    = b;
    r.has_byte = 1'b1;
    r.last     = 1'b0;
    step_results.push_back(r);
  endtask

  task automatic clear_scan();
    held_n    = 0;
    scan_mode = upd_pkg::MODE_PLAIN;
  endtask

  task automatic hold_char(input logic [7:0] c);
    if (held_n < 5) begin
      held_buf[held_n] = c;
      held_n++;
    end
  endtask

  // Held chars from index 'from' on, then 'extra', go back ahead of the replay queue.
  task automatic replay_held(input int unsigned from, input bit with_extra,
                             input logic [7:0] extra);
    logic [7:0] tmp [$];
    for (int unsigned i = from; i < held_n; i++) tmp.push_back(held_buf[i]);
    if (with_extra) tmp.push_back(extra);
    replay_q = {tmp, replay_q};
  endtask

  function automatic entity_match_e entity_state(input logic [7:0] c);
    int unsigned len;
    bit ap, am;
    logic [7:0] ch;
    len = held_n;
    ap  = (len <= 5);
    am  = (len <= 4);
    for (int unsigned k = 1; k <= len; k++) begin
      ch = (k < len) ? held_buf[k] : c;
      if (ap && ch != APOS_SEQ[k-1]) ap = 1'b0;
      if (am && ch != AMP_SEQ[k-1]) am = 1'b0;
    end
    if (ap && len == 5) return MATCH_APOS;
    if (am && len == 4) return MATCH_AMP;
    return (ap || am) ? MATCH_OPEN : MATCH_NONE;
  endfunction

  task automatic scan_char(input logic [7:0] c);
    int hi, lo;
    entity_match_e m;
    if (scan_mode == upd_pkg::MODE_PCT) begin
      if (held_n <= 1) begin
        if (hex_value(c) >= 0) begin
          hold_char(c);
        end else begin
          clear_scan();
          replay_held(0, 1'b1, c);
        end
      end else begin
        hi = hex_value(held_buf[1]);
        lo = hex_value(c);
        if (hi >= 0 && lo >= 0) begin
          clear_scan();
          push_byte({hi[3:0], lo[3:0]});
          escapes_seen++;
        end else begin
          replay_held(1, 1'b1, c);
          clear_scan();
        end
      end
    end else if (scan_mode == upd_pkg::MODE_AMP) begin
      m = entity_state(c);
      case (m)
        MATCH_APOS: begin
          clear_scan();
          push_byte(upd_pkg::CH_QUOTE);
          entities_seen++;
        end
        MATCH_AMP: begin
          clear_scan();
          push_byte(upd_pkg::CH_AMP);
          entities_seen++;
        end
        MATCH_OPEN: hold_char(c);
        default: begin
          // not an entity: '&' goes out as is, the rest is scanned again
          push_byte(upd_pkg::CH_AMP);
          replay_held(1, 1'b1, c);
          clear_scan();
        end
      endcase
    end else begin
      if (c == upd_pkg::CH_PCT) begin
        held_n = 0;
        hold_char(c);
        scan_mode = upd_pkg::MODE_PCT;
      end else if (c == upd_pkg::CH_AMP) begin
        held_n = 0;
        hold_char(c);
        scan_mode = upd_pkg::MODE_AMP;
      end else begin
        push_byte(c);
      end
    end
  endtask

  task automatic run_replay();
    logic [7:0] c;
    while (replay_q.size() > 0) begin
      c = replay_q.pop_front();
      scan_char(c);
    end
  endtask

  // Results one character request causes, left in step_results.
  task automatic decode_request(input char_req_t req);
    decode_result_t r;
    step_results = {};
    replay_q     = {req.ch};
    run_replay();
    if (req.is_last) begin
      // end of string: resolve whatever is still held
      while (held_n > 0) begin
        if (scan_mode == upd_pkg::MODE_PCT) begin
          if (held_n > 1) replay_held(1, 1'b0, 8'h00);
          clear_scan();
        end else begin
          push_byte(upd_pkg::CH_AMP);
          replay_held(1, 1'b0, 8'h00);
          clear_scan();
        end
        run_replay();
      end
      if (step_results.size() > 0) begin
        r = step_results.pop_back();
        r.last = 1'b1;
      end else begin
        r.value    = 8'h00;
        r.has_byte = 1'b0;
        r.last     = 1'b1;
      end
      step_results.push_back(r);
    end
  endtask

  // Drive one request, wait for the handshake, record what it must produce.
  task automatic offer_char(input char_req_t req, input row_kind_e kind,
                            input decode_result_t typed);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata  <= req.ch;
    s_tlast  <= req.is_last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    chars_sent++;
    if (req.is_last) strings_sent++;
    decode_request(req);
    case (kind)
      PREDICTED:  foreach (step_results[k]) pending_bytes.push_back(step_results[k]);
      ONE_RESULT: pending_bytes.push_back(typed);
      default: ;
    endcase
    if (calm_left > 0) begin
      calm_left--;
      gap = 0;
    end else begin
      if ($urandom_range(0, 39) == 0) calm_left = 20;
      gap = idle_cycles();
    end
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [7:0] rand_hex_digit();
    int v;
    v = $urandom_range(0, 21);
    if (v < 10) return 8'h30 + v[7:0];
    if (v < 16) return 8'h61 + v[7:0] - 8'd10;
    return 8'h41 + v[7:0] - 8'd16;
  endfunction

  function automatic logic [7:0] rand_non_hex();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (hex_value(c) >= 0);
    return c;
  endfunction

  task automatic add_char(input logic [7:0] c);
    char_req_t r;
    r.ch      = c;
    r.is_last = ($urandom_range(0, 29) == 0);  // now and then a string ends mid-token
    random_q.push_back(r);
  endtask

  // Plain characters, well-formed escapes and entities, broken ones and noise.
  task automatic queue_random_token();
    int pick, n;
    logic [7:0] c;
    char_req_t r;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      do c = 8'($urandom_range(0, 255));
      while (c == upd_pkg::CH_PCT || c == upd_pkg::CH_AMP);
      add_char(c);
    end else if (pick < 50) begin
      add_char(upd_pkg::CH_PCT);
      add_char(rand_hex_digit());
      add_char(rand_hex_digit());
    end else if (pick < 58) begin
      add_char(upd_pkg::CH_AMP);
      foreach (APOS_SEQ[i]) add_char(APOS_SEQ[i]);
    end else if (pick < 66) begin
      add_char(upd_pkg::CH_AMP);
      foreach (AMP_SEQ[i]) add_char(AMP_SEQ[i]);
    end else if (pick < 76) begin
      add_char(upd_pkg::CH_PCT);
      if ($urandom_range(0, 1)) add_char(rand_hex_digit());
      add_char(rand_non_hex());
    end else if (pick < 86) begin
      // entity prefix cut short by an arbitrary character
      add_char(upd_pkg::CH_AMP);
      n = $urandom_range(0, 3);
      for (int i = 0; i < n; i++) begin
        if (pick < 81) add_char(APOS_SEQ[i]);
        else add_char(AMP_SEQ[i]);
      end
      add_char(8'($urandom_range(0, 255)));
    end else begin
      add_char(8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 3) == 0) begin
      r = random_q.pop_back();
      r.is_last = 1'b1;
      random_q.push_back(r);
    end
  endtask

  task automatic check_field(input string what, input logic [31:0] expected,
                             input logic [31:0] actual);
    if (actual !== expected) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, expected, actual);
    end
  endtask

  // Result checker: every accepted result against the oldest expectation.
  always @(posedge clk) begin
    decode_result_t exp_r;
    if (!rst && m_tvalid && m_tready) begin
      results_checked++;
      if (pending_bytes.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("%0t: unexpected result, expected none, got %0h/%b/%b",
                   $time, m_tdata, m_tuser, m_tlast);
      end else begin
        exp_r = pending_bytes.pop_front();
        check_field("out_byte", 32'(exp_r.value), 32'(m_tdata));
        check_field("has_byte", 32'(exp_r.has_byte), 32'(m_tuser));
        check_field("last", 32'(exp_r.last), 32'(m_tlast));
      end
    end
  end

  // Receiver: random stalls, one long hold-off once traffic is flowing.
  initial begin
    int gap;
    bit long_done;
    long_done = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (!long_done && results_checked >= HOLD_AFTER) begin
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_done = 1'b1;
      end else begin
        gap = idle_cycles();
        if (gap > 0) begin
          m_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        m_tready <= 1'b1;
        if ($urandom_range(0, 19) == 0) repeat (40) @(posedge clk);
        else repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  // Sender: directed table, then random tokens, then drain.
  initial begin
    char_req_t req;
    decode_result_t typed;
    int pause_at;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DIRECTED_ROWS[i]) begin
      req.ch         = DIRECTED_ROWS[i].ch;
      req.is_last    = DIRECTED_ROWS[i].is_last;
      typed.value    = DIRECTED_ROWS[i].value;
      typed.has_byte = DIRECTED_ROWS[i].has_byte;
      typed.last     = DIRECTED_ROWS[i].last;
      offer_char(req, DIRECTED_ROWS[i].kind, typed);
    end

    while (random_q.size() < RANDOM_ITEMS) queue_random_token();
    req = random_q.pop_back();
    req.is_last = 1'b1;
    random_q.push_back(req);

    typed    = '0;
    pause_at = random_q.size() / 2 + $urandom_range(0, 20);
    foreach (random_q[i]) begin
      if (i == pause_at) begin
        // sender goes quiet until the block has delivered everything
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending_bytes.size() != 0);
      end
      offer_char(random_q[i], PREDICTED, typed);
    end
    s_tvalid <= 1'b0;

    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d characters in %0d strings, %0d results checked",
             chars_sent, strings_sent, results_checked);
    $display("decoded %0d percent escapes and %0d entities, output held off %0d cycles once",
             escapes_seen, entities_seen, LONG_HOLD);
    if (fail_count == 0 && pending_bytes.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog, well beyond the slowest legal run.
  initial begin
    #4000000;
    $display("timeout with %0d results outstanding", pending_bytes.size());
    $display("simulation failed");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/upd_pkg.sv
rtl/upd_step.sv
rtl/upd_out.sv
rtl/uri_percent_entity_decoder.sv
rtl/upd_checker.sv
tb/uri_percent_entity_decoder_test.sv
